// ===== rtl/core/mwtp_pkg.sv =====
// package for the minimum window two-pointer block
// widths, command codes and controller/datapath interface structs; no dependencies
`default_nettype none

package mwtp_pkg;

  localparam int unsigned MAX_TEXT = 4096;
  localparam int unsigned TEXT_AW  = $clog2(MAX_TEXT);
  localparam int unsigned CNT_W    = $clog2(MAX_TEXT + 1);
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned NEED_W   = 14;
  localparam int unsigned PAT_W    = 13;
  localparam int unsigned START_W  = TEXT_AW;
  localparam int unsigned LEN_W    = CNT_W;

  localparam logic [PAT_W-1:0] PAT_LIMIT = {PAT_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH  = 2'd2;

  typedef struct packed {
    logic pat_rd;
    logic pat_wr;
    logic txt_in;
    logic txt_ovf;
    logic txt_upd;
    logic head_nd;
    logic head_upd;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic pat_ok;
    logic txt_ok;
    logic shrink_go;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/mwtp_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module mwtp_ram #(
  parameter int unsigned DW = 8,
  parameter int unsigned AW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/mwtp_dp.sv =====
// datapath: need counts, presence marks, text buffer, window and best-window registers
// depends on mwtp_pkg and mwtp_ram
`default_nettype none

module mwtp_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [mwtp_pkg::CHAR_W-1:0] char_value_i,
  input  wire mwtp_pkg::dp_cmd_t           cmd_i,
  output mwtp_pkg::dp_stat_t               stat_o,
  output logic                             found_o,
  output logic [mwtp_pkg::START_W-1:0]     window_start_o,
  output logic [mwtp_pkg::LEN_W-1:0]       window_length_o,
  output logic                             overflow_o
);
  import mwtp_pkg::*;

  logic [CHAR_W-1:0]    char_q;
  logic [CHAR_W-1:0]    h_q;
  logic [CNT_W-1:0]     tail_q;
  logic [CNT_W-1:0]     head_q;
  logic [CNT_W-1:0]     count_q;
  logic [PAT_W-1:0]     matched_q;
  logic [PAT_W-1:0]     patlen_q;
  logic [START_W-1:0]   best_begin_q;
  logic [LEN_W-1:0]     best_len_q;
  logic                 have_best_q;
  logic                 ovf_q;
  logic [2**CHAR_W-1:0] present_q;

  logic [CHAR_W-1:0] txt_rdata;
  logic [NEED_W-1:0] need_rdata;
  logic [CHAR_W-1:0] need_raddr;
  logic [CHAR_W-1:0] need_waddr;
  logic [NEED_W-1:0] need_wdata;
  logic              need_we;
  logic              cur_present;
  logic [NEED_W-1:0] eff;
  logic [NEED_W-1:0] eff_inc;
  logic [NEED_W-1:0] eff_dec;
  logic [CNT_W-1:0]  cand_len;

  function automatic logic is_pos(logic [NEED_W-1:0] v);
    is_pos = !v[NEED_W-1] && (v != '0);
  endfunction

  mwtp_ram #(.DW(CHAR_W), .AW(TEXT_AW)) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.txt_in),
    .waddr_i (count_q[TEXT_AW-1:0]),
    .wdata_i (char_value_i),
    .raddr_i (head_q[TEXT_AW-1:0]),
    .rdata_o (txt_rdata)
  );

  mwtp_ram #(.DW(NEED_W), .AW(CHAR_W)) u_need_ram (
    .clk_i   (clk_i),
    .we_i    (need_we),
    .waddr_i (need_waddr),
    .wdata_i (need_wdata),
    .raddr_i (need_raddr),
    .rdata_o (need_rdata)
  );

  always_comb begin
    need_raddr  = cmd_i.head_nd ? txt_rdata : char_value_i;
    need_waddr  = cmd_i.head_upd ? h_q : char_q;
    cur_present = present_q[need_waddr];
    // entries never marked present read as zero
    eff         = cur_present ? need_rdata : '0;
    eff_inc     = eff + NEED_W'(1);
    eff_dec     = eff - NEED_W'(1);
    need_wdata  = cmd_i.txt_upd ? eff_dec : eff_inc;
    need_we     = cmd_i.pat_wr || ((cmd_i.txt_upd || cmd_i.head_upd) && cur_present);
    cand_len    = tail_q - head_q + CNT_W'(1);
  end

  assign stat_o.pat_ok    = (count_q == '0) && !ovf_q && (patlen_q != PAT_LIMIT);
  assign stat_o.txt_ok    = !ovf_q && (count_q < CNT_W'(MAX_TEXT));
  assign stat_o.shrink_go = (patlen_q != '0) && (matched_q == patlen_q) && (head_q < count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.pat_rd || cmd_i.txt_in) begin
      char_q <= char_value_i;
    end
    if (cmd_i.txt_in) begin
      tail_q <= count_q;
    end
    if (cmd_i.head_nd) begin
      h_q <= txt_rdata;
    end
    if (cmd_i.finish) begin
      found_o         <= have_best_q && !ovf_q;
      window_start_o  <= (have_best_q && !ovf_q) ? best_begin_q : '0;
      window_length_o <= (have_best_q && !ovf_q) ? best_len_q : '0;
      overflow_o      <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      count_q      <= '0;
      matched_q    <= '0;
      patlen_q     <= '0;
      best_begin_q <= '0;
      best_len_q   <= '0;
      have_best_q  <= 1'b0;
      ovf_q        <= 1'b0;
      present_q    <= '0;
    end else if (cmd_i.finish) begin
      head_q       <= '0;
      count_q      <= '0;
      matched_q    <= '0;
      patlen_q     <= '0;
      best_begin_q <= '0;
      best_len_q   <= '0;
      have_best_q  <= 1'b0;
      ovf_q        <= 1'b0;
      present_q    <= '0;
    end else begin
      if (cmd_i.pat_wr) begin
        present_q[char_q] <= 1'b1;
        patlen_q          <= patlen_q + PAT_W'(1);
      end
      if (cmd_i.txt_ovf) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.txt_in) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.txt_upd && cur_present && is_pos(eff)) begin
        matched_q <= matched_q + PAT_W'(1);
      end
      if (cmd_i.head_upd) begin
        head_q <= head_q + CNT_W'(1);
        if (cur_present && is_pos(eff_inc)) begin
          matched_q <= matched_q - PAT_W'(1);
          if (!have_best_q || (cand_len < best_len_q)) begin
            have_best_q  <= 1'b1;
            best_len_q   <= cand_len;
            best_begin_q <= head_q[START_W-1:0];
          end
        end
      end
    end
  end

  a_matched_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    matched_q <= patlen_q) else $error("matched count above pattern length");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= count_q) else $error("window head past text end");

  a_best_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_best_q |-> (best_len_q != '0) && (best_len_q <= count_q))
    else $error("best window length out of range");

endmodule

`default_nettype wire

// ===== rtl/core/mwtp_ctrl.sv =====
// controller state machine: request handshake, sequencing of datapath steps, result slot
// depends on mwtp_pkg
`default_nettype none

module mwtp_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [mwtp_pkg::CMD_W-1:0] cmd_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  input  wire mwtp_pkg::dp_stat_t         stat_i,
  output mwtp_pkg::dp_cmd_t               dp_cmd_o
);
  import mwtp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAT,
    S_TXT,
    S_CHK,
    S_HB,
    S_HN
  } state_e;

  state_e state_q;
  logic   slot_free;
  logic   accept;

  assign slot_free  = !out_valid_o || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || ((cmd_i == CMD_FINISH) && !slot_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    dp_cmd_o          = '0;
    dp_cmd_o.pat_rd   = accept && (cmd_i == CMD_PATTERN) && stat_i.pat_ok;
    dp_cmd_o.txt_in   = accept && (cmd_i == CMD_TEXT) && stat_i.txt_ok;
    dp_cmd_o.txt_ovf  = accept && (cmd_i == CMD_TEXT) && !stat_i.txt_ok;
    dp_cmd_o.finish   = accept && (cmd_i == CMD_FINISH);
    dp_cmd_o.pat_wr   = (state_q == S_PAT);
    dp_cmd_o.txt_upd  = (state_q == S_TXT);
    dp_cmd_o.head_nd  = (state_q == S_HB);
    dp_cmd_o.head_upd = (state_q == S_HN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      if (dp_cmd_o.finish) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (dp_cmd_o.pat_rd) begin
            state_q <= S_PAT;
          end else if (dp_cmd_o.txt_in) begin
            state_q <= S_TXT;
          end
        end
        S_PAT:  state_q <= S_IDLE;
        S_TXT:  state_q <= S_CHK;
        S_CHK: begin
          state_q <= stat_i.shrink_go ? S_HB : S_IDLE;
        end
        S_HB:   state_q <= S_HN;
        S_HN:   state_q <= S_CHK;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_finish_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_o.finish |=> out_valid_o) else $error("finish request gave no result");

endmodule

`default_nettype wire

// ===== rtl/core/min_window_two_pointer.sv =====
// Minimum window finder, two-pointer form. Send pattern bytes (cmd 0), then text bytes
// (cmd 1), then a finish request (cmd 2), which returns found, start, length and overflow
// and clears the job. A pattern byte takes a write step (S_PAT) and a text byte an update
// step (S_TXT) and a check (S_CHK), plus S_HB, S_HN and a new check for each step the window
// head advances; finish and ignored requests need no further step. The steps come from the
// need-count ram with registered read, which each step reads, updates and writes back.
// Every request is held off while a byte is in progress, and a finish request also while
// an earlier result still waits on the output. Up to 4096 text bytes per job.
// depends on mwtp_pkg, mwtp_ctrl, mwtp_dp
`default_nettype none

module min_window_two_pointer (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [mwtp_pkg::CMD_W-1:0]  cmd_i,
  input  wire logic [mwtp_pkg::CHAR_W-1:0] char_value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             found_o,
  output logic [mwtp_pkg::START_W-1:0]     window_start_o,
  output logic [mwtp_pkg::LEN_W-1:0]       window_length_o,
  output logic                             overflow_o
);
  import mwtp_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  mwtp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .dp_cmd_o    (dp_cmd)
  );

  mwtp_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .char_value_i    (char_value_i),
    .cmd_i           (dp_cmd),
    .stat_o          (dp_stat),
    .found_o         (found_o),
    .window_start_o  (window_start_o),
    .window_length_o (window_length_o),
    .overflow_o      (overflow_o)
  );

endmodule

`default_nettype wire

// ===== dv/min_window_two_pointer_tb.sv =====
// testbench for min_window_two_pointer: directed jobs, held-off output, random jobs
// predicts each finish result from its own copy of the tables; depends on mwtp_pkg and the rtl
`timescale 1ns / 100ps

module min_window_two_pointer_tb;
  import mwtp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    int unsigned       gap;
  } req_t;

  typedef struct {
    logic               found;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic               ovf;
  } window_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [CMD_W-1:0] cmd_d = CMD_PATTERN;
  logic [CHAR_W-1:0] char_d = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic found;
  logic [START_W-1:0] win_start;
  logic [LEN_W-1:0] win_len;
  logic ovf;

  req_t req_q[$];
  window_res_t window_q[$];
  logic quiet = 1'b0;
  logic long_hold_req = 1'b0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  // predictor state
  logic in_pattern [256];
  logic signed [NEED_W-1:0] need_cnt [256];
  logic [CHAR_W-1:0] text_mem [MAX_TEXT];
  logic [LEN_W-1:0] head;
  logic [LEN_W-1:0] text_cnt;
  logic [PAT_W-1:0] matched;
  logic [PAT_W-1:0] pat_len;
  logic [START_W-1:0] best_begin;
  logic [LEN_W-1:0] best_len;
  logic have_best;
  logic ovf_flag;

  min_window_two_pointer uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .cmd_i           (cmd_d),
    .char_value_i    (char_d),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .found_o         (found),
    .window_start_o  (win_start),
    .window_length_o (win_len),
    .overflow_o      (ovf)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic clear_tables();
    int i;
    for (i = 0; i < 256; i++) begin
      in_pattern[i] = 1'b0;
      need_cnt[i] = '0;
    end
    head = '0;
    text_cnt = '0;
    matched = '0;
    pat_len = '0;
    best_begin = '0;
    best_len = '0;
    have_best = 1'b0;
    ovf_flag = 1'b0;
  endtask

  task automatic window_step(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch);
    window_res_t res;
    logic [LEN_W-1:0] tail;
    logic [LEN_W-1:0] span;
    logic [CHAR_W-1:0] hc;
    case (cmd)
      CMD_PATTERN: begin
        if (text_cnt == 0 && !ovf_flag && pat_len < PAT_LIMIT) begin
          in_pattern[ch] = 1'b1;
          need_cnt[ch] = need_cnt[ch] + 14'sd1;
          pat_len = pat_len + 1'b1;
        end
      end
      CMD_TEXT: begin
        if (ovf_flag || text_cnt >= MAX_TEXT) begin
          ovf_flag = 1'b1;
        end else begin
          tail = text_cnt;
          text_mem[tail[TEXT_AW-1:0]] = ch;
          text_cnt = text_cnt + 1'b1;
          if (in_pattern[ch]) begin
            if (need_cnt[ch] > 0) matched = matched + 1'b1;
            need_cnt[ch] = need_cnt[ch] - 14'sd1;
          end
          while (pat_len != 0 && matched == pat_len && head < text_cnt) begin
            hc = text_mem[head[TEXT_AW-1:0]];
            if (in_pattern[hc]) begin
              need_cnt[hc] = need_cnt[hc] + 14'sd1;
              if (need_cnt[hc] > 0) begin
                span = tail - head + 1'b1;
                if (!have_best || span < best_len) begin
                  have_best = 1'b1;
                  best_len = span;
                  best_begin = head[START_W-1:0];
                end
                matched = matched - 1'b1;
              end
            end
            head = head + 1'b1;
          end
        end
      end
      CMD_FINISH: begin
        res.found = have_best && !ovf_flag;
        res.start = res.found ? best_begin : '0;
        res.len = res.found ? best_len : '0;
        res.ovf = ovf_flag;
        window_q.push_back(res);
        clear_tables();
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      if (err_cnt < 100)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      err_cnt++;
    end
  endtask

  // driver
  int unsigned idle_cnt = 0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      cmd_d <= CMD_PATTERN;
      char_d <= '0;
      idle_cnt <= 0;
    end else if (!in_valid || !in_stall) begin
      if (req_q.size() != 0 && idle_cnt >= req_q[0].gap) begin
        in_valid <= 1'b1;
        cmd_d <= req_q[0].cmd;
        char_d <= req_q[0].ch;
        req_q.delete(0);
        idle_cnt <= 0;
      end else begin
        in_valid <= 1'b0;
        if (idle_cnt < 16) idle_cnt <= idle_cnt + 1;
      end
    end
  end

  // receiver stall
  int unsigned hold_left = 0;
  int unsigned res_seen = 0;
  logic long_hold_done = 1'b0;

  always @(posedge clk or negedge rst_n) begin : stall_gen
    int unsigned d;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      res_seen <= 0;
      long_hold_done <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      d = (res_seen % 16 < 4) ? 0 : $urandom_range(0, 8);
      res_seen <= res_seen + 1;
      hold_left <= d;
      out_stall <= (d != 0);
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end
  end

  // monitor
  always @(posedge clk or negedge rst_n) begin : mon
    window_res_t want;
    if (!rst_n) begin
      clear_tables();
    end else begin
      if (in_valid && !in_stall) window_step(cmd_d, char_d);
      if (out_valid && !out_stall) begin
        if (window_q.size() == 0) begin
          if (err_cnt < 100)
            $display("%0t: result with none pending, expected none actual %0d %0d %0d %0d",
                     $time, found, win_start, win_len, ovf);
          err_cnt++;
        end else begin
          want = window_q.pop_front();
          check_field("found", want.found, found);
          check_field("window_start", want.start, win_start);
          check_field("window_length", want.len, win_len);
          check_field("overflow", want.ovf, ovf);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_req(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch);
    req_t r;
    r.cmd = cmd;
    r.ch = ch;
    r.gap = quiet ? 0 : $urandom_range(0, 8);
    req_q.push_back(r);
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid || window_q.size() != 0) @(negedge clk);
  endtask

  task automatic queue_random_job(output int unsigned counted);
    logic [CHAR_W-1:0] alpha [6];
    int unsigned n_alpha, n_pat, n_text, kind, pick, i;
    counted = 0;
    quiet = ($urandom_range(0, 4) == 0);
    kind = $urandom_range(0, 19);
    n_alpha = $urandom_range(1, 6);
    for (i = 0; i < 6; i++) alpha[i] = CHAR_W'($urandom_range(0, 255));
    n_pat = (kind == 0) ? 0 : $urandom_range(1, 6);
    n_text = (kind == 1) ? 0 : $urandom_range(0, 30);
    for (i = 0; i < n_pat; i++) begin
      push_req(CMD_PATTERN, alpha[$urandom_range(0, n_alpha - 1)]);
      counted++;
    end
    for (i = 0; i < n_text; i++) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        push_req(CMD_UNUSED, CHAR_W'($urandom_range(0, 255)));
      end else if (pick == 1) begin
        push_req(CMD_PATTERN, CHAR_W'($urandom_range(0, 255)));
      end else begin
        push_req(CMD_TEXT, (pick == 2) ? CHAR_W'($urandom_range(0, 255))
                                       : alpha[$urandom_range(0, n_alpha - 1)]);
        counted++;
      end
    end
    // some jobs run on without a finish
    if (kind != 2) begin
      push_req(CMD_FINISH, CHAR_W'($urandom_range(0, 255)));
      counted++;
    end
  endtask

  initial begin : stim
    int unsigned i, n, total, jobs;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty job
    push_req(CMD_FINISH, 8'h00);
    // extreme bytes, unused command, late pattern byte
    push_req(CMD_PATTERN, 8'h00);
    push_req(CMD_PATTERN, 8'hFF);
    push_req(CMD_UNUSED, 8'h5A);
    push_req(CMD_TEXT, 8'hFF);
    push_req(CMD_TEXT, 8'h00);
    push_req(CMD_PATTERN, 8'h33);
    push_req(CMD_FINISH, 8'hFF);
    // repeated pattern bytes
    push_req(CMD_PATTERN, 8'h41);
    push_req(CMD_PATTERN, 8'h41);
    push_req(CMD_PATTERN, 8'h42);
    push_req(CMD_TEXT, 8'h41);
    push_req(CMD_TEXT, 8'h42);
    push_req(CMD_TEXT, 8'h43);
    push_req(CMD_TEXT, 8'h41);
    push_req(CMD_TEXT, 8'h41);
    push_req(CMD_TEXT, 8'h42);
    push_req(CMD_FINISH, 8'h00);
    // text with empty pattern
    push_req(CMD_TEXT, 8'h55);
    push_req(CMD_TEXT, 8'hAA);
    push_req(CMD_FINISH, 8'h00);
    // no match
    push_req(CMD_PATTERN, 8'h7E);
    push_req(CMD_TEXT, 8'h01);
    push_req(CMD_FINISH, 8'h00);
    // tie goes to the earliest window
    push_req(CMD_PATTERN, 8'h10);
    push_req(CMD_TEXT, 8'h10);
    push_req(CMD_TEXT, 8'h10);
    push_req(CMD_FINISH, 8'h00);
    wait_drained();

    // output held off while the sender keeps going
    long_hold_req = 1'b1;
    push_req(CMD_FINISH, 8'h00);
    push_req(CMD_FINISH, 8'h00);
    for (i = 0; i < 6; i++) queue_random_job(n);
    push_req(CMD_FINISH, 8'h00);
    wait_drained();
    quiet = 1'b0;

    total = 0;
    jobs = 0;
    while (total < 680 || jobs < 40) begin
      queue_random_job(n);
      total += n;
      jobs++;
    end
    push_req(CMD_FINISH, 8'h00);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_cnt == 0 && window_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
